// ===== src/nrsd_pkg.sv =====
// ----------------------------------------------------------------------------
// nrsd_pkg: shared types and constants
// Event codes, step codes, fixed field widths, reset values and the no-anchor code.
// ----------------------------------------------------------------------------
package nrsd_pkg;

  // fixed field widths
  localparam int unsigned OpBits       = 2;
  localparam int unsigned StepBits     = 2;
  localparam int unsigned CooldownBits = 16;
  localparam int unsigned OutPosBits   = 32;
  localparam int unsigned MarkBits     = 3;

  // register reset values
  localparam logic [CooldownBits-1:0] CooldownReset = 16'd1000;

  // anchor code for "no anchor": clock marks 0..1, data marks 2..3
  localparam logic [MarkBits-1:0] AnchorNone = 3'd4;

  // event kinds, the fourth code is unused
  typedef enum logic [OpBits-1:0] {
    OP_CLOCK  = 2'd0,
    OP_DATA   = 2'd1,
    OP_SWITCH = 2'd2
  } op_e;

  // detected turn
  typedef enum logic [StepBits-1:0] {
    STEP_NONE = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2
  } step_e;

endpackage

// ===== src/nrsd_intf.sv =====
// ----------------------------------------------------------------------------
// nrsd_intf: channel interfaces
// Event input, result output and cooldown write channels, valid/ready.
// ----------------------------------------------------------------------------

// edge event channel
interface nrsd_event_if #(
  parameter int unsigned TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic                 other_level;
  logic [TIME_BITS-1:0] time_us;

  modport source (output valid, opcode, other_level, time_us, input ready);
  modport sink   (input valid, opcode, other_level, time_us, output ready);
endinterface

// decoded result channel
interface nrsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  step;
  logic [31:0] position;
  logic        button_on;

  modport source (output valid, step, position, button_on, input ready);
  modport sink   (input valid, step, position, button_on, output ready);
endinterface

// cooldown register write channel
interface nrsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/nrsd_core.sv =====
// ----------------------------------------------------------------------------
// nrsd_core: decoder state and single-pass update
// Holds phases, anchor, flags, position, button and last edge time, and
// computes the state after one event in one combinational pass.
// ----------------------------------------------------------------------------
module nrsd_core
  import nrsd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  op_e                      op_i,
  input  logic                     other_i,
  input  logic [TIME_BITS-1:0]     time_i,
  input  logic [CooldownBits-1:0]  cooldown_i,
  output step_e                    step_o,
  output logic [POSITION_BITS-1:0] pos_o,
  output logic                     button_o
);

  logic [TIME_BITS-1:0]     last_q, last_d;
  logic                     button_q, button_d;
  logic                     clk_phase_q, clk_phase_d;
  logic                     dat_phase_q, dat_phase_d;
  logic [MarkBits-1:0]      anchor_q, anchor_d;
  logic                     seen_phase_q, seen_phase_d;
  logic                     seen_cross_q, seen_cross_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  step_e                    step_d;

  logic                 line;
  logic                 phase;
  logic                 a_valid;
  logic                 a_line;
  logic                 a_phase;
  logic [TIME_BITS-1:0] diff;

  // current mark and anchor fields
  assign line    = (op_i == OP_DATA);
  assign phase   = line ? dat_phase_q : clk_phase_q;
  assign a_valid = !anchor_q[2];
  assign a_line  = anchor_q[1];
  assign a_phase = anchor_q[0];
  assign diff    = time_i - last_q;

  // next state for one event
  always_comb begin
    last_d       = last_q;
    button_d     = button_q;
    clk_phase_d  = clk_phase_q;
    dat_phase_d  = dat_phase_q;
    anchor_d     = anchor_q;
    seen_phase_d = seen_phase_q;
    seen_cross_d = seen_cross_q;
    pos_d        = pos_q;
    step_d       = STEP_NONE;
    case (op_i)
      OP_CLOCK, OP_DATA: begin
        last_d = time_i;
        if (line) begin
          dat_phase_d = !dat_phase_q;
        end else begin
          clk_phase_d = !clk_phase_q;
        end
        if (other_i) begin
          // start mark: maybe step, then re-anchor
          if (a_valid && seen_phase_q && seen_cross_q && (line != a_line)) begin
            if (!a_line) begin
              pos_d  = pos_q + POSITION_BITS'(1);
              step_d = STEP_INC;
            end else begin
              pos_d  = pos_q - POSITION_BITS'(1);
              step_d = STEP_DEC;
            end
          end
          anchor_d     = {1'b0, line, phase};
          seen_phase_d = 1'b0;
          seen_cross_d = 1'b0;
        end else if (a_valid) begin
          // phase mark against the anchor
          if ((line == a_line) && (phase != a_phase)) begin
            seen_phase_d = 1'b1;
          end
          if (line != a_line) begin
            seen_cross_d = 1'b1;
          end
        end
      end
      OP_SWITCH: begin
        // toggle only after the cooldown
        if (diff >= TIME_BITS'(cooldown_i)) begin
          button_d = !button_q;
          last_d   = time_i;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= '0;
      button_q     <= 1'b0;
      clk_phase_q  <= 1'b0;
      dat_phase_q  <= 1'b0;
      anchor_q     <= AnchorNone;
      seen_phase_q <= 1'b0;
      seen_cross_q <= 1'b0;
      pos_q        <= '0;
    end else if (en_i) begin
      last_q       <= last_d;
      button_q     <= button_d;
      clk_phase_q  <= clk_phase_d;
      dat_phase_q  <= dat_phase_d;
      anchor_q     <= anchor_d;
      seen_phase_q <= seen_phase_d;
      seen_cross_q <= seen_cross_d;
      pos_q        <= pos_d;
    end
  end

  // result reflects the state after the event
  assign step_o   = step_d;
  assign pos_o    = pos_d;
  assign button_o = button_d;

`ifndef SYNTH
  // a step always leaves both flags cleared
  a_step_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && (step_d != STEP_NONE)) |=> (!seen_phase_q && !seen_cross_q))
    else $error("flags not cleared after step");

  // anchor never holds an unused code
  a_anchor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (anchor_q <= AnchorNone))
    else $error("anchor holds unused code");

  // flags only get set once an anchor exists
  a_flags_need_anchor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_phase_q || seen_cross_q) |-> a_valid)
    else $error("flag set without anchor");

  // a clock edge flips the clock phase
  a_clk_phase_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && (op_i == OP_CLOCK)) |=> (clk_phase_q != $past(clk_phase_q)))
    else $error("clock phase did not flip");
`endif

endmodule

// ===== src/noisy_rotary_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// noisy_rotary_sequence_decoder: rotary encoder edge sequence decoder
// Registers each edge event, decodes it against the stored sequence state
// and registers one result per event.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  in_i     | in  | valid/ready  | opcode, other_level, time_us
//  out_o    | out | valid/ready  | step, position, button_on
//  cfg_i    | in  | valid/ready  | data (cooldown_us), ready tied high
//
//  Each event is held in the input register and is decoded as it moves to
//  the result register, so one event per cycle is sustained while results
//  are taken; the decoded result is held in the result register until it
//  transfers. Reset clears the decoder state and the valid flags; cooldown
//  resets to 1000 us.
//  A stalled result holds the pipeline; the input register still takes an
//  event while it is empty.
//
module noisy_rotary_sequence_decoder
  import nrsd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  nrsd_event_if.sink    in_i,
  nrsd_result_if.source out_o,
  nrsd_cfg_if.sink      cfg_i
);

  logic [CooldownBits-1:0] cooldown_q;

  logic                 in_vld_q;
  logic [OpBits-1:0]    in_op_q;
  logic                 in_other_q;
  logic [TIME_BITS-1:0] in_time_q;

  logic                  out_vld_q;
  logic [StepBits-1:0]   out_step_q;
  logic [OutPosBits-1:0] out_pos_q;
  logic                  out_button_q;

  logic                     adv;
  logic                     fire;
  step_e                    core_step;
  logic [POSITION_BITS-1:0] core_pos;
  logic [OutPosBits-1:0]    core_pos_ext;
  logic                     core_button;

  // pipeline flow control
  assign adv         = !out_vld_q || out_o.ready;
  assign fire        = in_vld_q && adv;
  assign in_i.ready  = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  // cooldown register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q <= CooldownReset;
    end else if (cfg_i.valid) begin
      cooldown_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q    <= in_i.opcode;
      in_other_q <= in_i.other_level;
      in_time_q  <= in_i.time_us;
    end
  end

  // decode and state update
  nrsd_core #(
    .POSITION_BITS (POSITION_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .op_i       (op_e'(in_op_q)),
    .other_i    (in_other_q),
    .time_i     (in_time_q),
    .cooldown_i (cooldown_q),
    .step_o     (core_step),
    .pos_o      (core_pos),
    .button_o   (core_button)
  );

  // position reported on 32 bits
  generate
    if (POSITION_BITS >= OutPosBits) begin : g_pos_trunc
      assign core_pos_ext = core_pos[OutPosBits-1:0];
    end else begin : g_pos_ext
      assign core_pos_ext = {{(OutPosBits-POSITION_BITS){1'b0}}, core_pos};
    end
  endgenerate

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_step_q   <= core_step;
      out_pos_q    <= core_pos_ext;
      out_button_q <= core_button;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.step      = out_step_q;
  assign out_o.position  = out_pos_q;
  assign out_o.button_on = out_button_q;

`ifndef SYNTH
  // an event waiting on a stalled result stays in the input register
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("event lost while result stalled");

  // a decoded event always shows up as a result next cycle
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("decoded event produced no result");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(out_step_q) &&
      $stable(out_pos_q) && $stable(out_button_q)))
    else $error("result changed while stalled");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rotary sequence decoder check
// Sends clock-line, data-line, switch and unused-opcode edge events, predicts each decoded
// result from a local model of the mark/anchor logic and the cooldown, and
// compares every result field by field under random idling and backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import nrsd_pkg::*;

  localparam int          ClkHalf       = 4;
  localparam int          ResetCycles   = 8;
  localparam int          HoldCycles    = 200;
  localparam int          WatchdogLimit = 4000;
  localparam int          DrainCycles   = 8;
  localparam int          MaxReports    = 50;
  localparam logic [1:0]  OpUnused      = 2'd3;

  typedef struct packed {
    step_e       step;
    logic [31:0] position;
    logic        button_on;
  } decoded_t;

  logic clk;
  logic rst_ni;

  nrsd_event_if #(.TIME_BITS(32)) ev_if ();
  nrsd_result_if                  res_if ();
  nrsd_cfg_if                     cfg_if ();

  noisy_rotary_sequence_decoder #(
    .POSITION_BITS(32),
    .TIME_BITS    (32)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (ev_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  // decoder model state, reset values
  logic [15:0] cooldown_mdl    = CooldownReset;
  logic [31:0] last_edge_mdl   = '0;
  logic        button_mdl      = 1'b0;
  logic        clock_phase_mdl = 1'b0;
  logic        data_phase_mdl  = 1'b0;
  logic [2:0]  anchor_mdl      = AnchorNone;
  logic        seen_phase_mdl  = 1'b0;
  logic        seen_cross_mdl  = 1'b0;
  logic [31:0] turn_count_mdl  = '0;

  decoded_t    expected_results[$];

  // bookkeeping
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          error_count   = 0;
  int          inc_seen      = 0;
  int          dec_seen      = 0;
  int          settings_used = 0;
  int          quiet_cycles  = 0;
  logic [31:0] now_us        = '0;
  bit          sender_idle_en   = 1'b1;
  bit          receiver_idle_en = 1'b1;
  bit          hold_pending     = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // one mark against the anchor and flags
  function automatic step_e apply_mark(input logic line, input logic phase,
                                       input logic start);
    logic  anchored;
    logic  a_line;
    logic  a_phase;
    step_e s;
    anchored = (anchor_mdl < AnchorNone);
    a_line   = anchor_mdl[1];
    a_phase  = anchor_mdl[0];
    s        = STEP_NONE;
    if (start) begin
      if (anchored && seen_phase_mdl && seen_cross_mdl && line != a_line) begin
        if (!a_line) begin
          turn_count_mdl = turn_count_mdl + 32'd1;
          s              = STEP_INC;
        end else begin
          turn_count_mdl = turn_count_mdl - 32'd1;
          s              = STEP_DEC;
        end
      end
      anchor_mdl     = {1'b0, line, phase};
      seen_phase_mdl = 1'b0;
      seen_cross_mdl = 1'b0;
    end else if (anchored) begin
      if (line == a_line && phase != a_phase) seen_phase_mdl = 1'b1;
      if (line != a_line) seen_cross_mdl = 1'b1;
    end
    return s;
  endfunction

  // full event decode, updates model state
  function automatic decoded_t decode_event(input logic [1:0] op, input logic lvl,
                                            input logic [31:0] t);
    decoded_t    r;
    logic [31:0] since;
    r.step = STEP_NONE;
    case (op)
      OP_CLOCK: begin
        last_edge_mdl   = t;
        r.step          = apply_mark(1'b0, clock_phase_mdl, lvl);
        clock_phase_mdl = ~clock_phase_mdl;
      end
      OP_DATA: begin
        last_edge_mdl  = t;
        r.step         = apply_mark(1'b1, data_phase_mdl, lvl);
        data_phase_mdl = ~data_phase_mdl;
      end
      OP_SWITCH: begin
        since = t - last_edge_mdl;
        if (since >= {16'd0, cooldown_mdl}) begin
          button_mdl    = ~button_mdl;
          last_edge_mdl = t;
        end
      end
      default: begin
      end
    endcase
    r.position  = turn_count_mdl;
    r.button_on = button_mdl;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxReports)
      $display("[%0t] mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
  endtask

  // predict on every input transfer, track register writes
  always @(posedge clk) begin
    if (rst_ni && ev_if.valid && ev_if.ready)
      expected_results.push_back(decode_event(ev_if.opcode, ev_if.other_level,
                                              ev_if.time_us));
    if (rst_ni && cfg_if.valid && cfg_if.ready)
      cooldown_mdl = cfg_if.data;
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    decoded_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res_if.position, '0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.step !== want.step)
          report_mismatch("step", {30'd0, res_if.step}, {30'd0, want.step});
        if (res_if.position !== want.position)
          report_mismatch("position", res_if.position, want.position);
        if (res_if.button_on !== want.button_on)
          report_mismatch("button_on", {31'd0, res_if.button_on}, {31'd0, want.button_on});
      end
      if (res_if.step === STEP_INC) inc_seen++;
      if (res_if.step === STEP_DEC) dec_seen++;
      results_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_ni || (ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  initial begin
    int k;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        res_if.ready <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(posedge clk);
        hold_pending = 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one event transfer, with an optional idle burst ahead of it
  task automatic send_event(input logic [1:0] op, input logic lvl, input logic [31:0] t);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      ev_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    ev_if.valid       <= 1'b1;
    ev_if.opcode      <= op;
    ev_if.other_level <= lvl;
    ev_if.time_us     <= t;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait for every predicted result
  task automatic drain_results();
    ev_if.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_cooldown(input logic [15:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // four quadrature edges; drop 0..3 removes one edge to break the sequence
  task automatic send_detent(input logic up, input int drop, input int max_gap);
    int   i;
    logic line;
    for (i = 0; i < 4; i++) begin
      line   = up ? i[0] : ~i[0];
      now_us = now_us + $urandom_range(1, max_gap);
      if (i != drop)
        send_event(line ? OP_DATA : OP_CLOCK, (i == 0 || i == 3), now_us);
    end
  endtask

  task automatic test_reset_cooldown();
    // default cooldown: below and at the threshold from time zero
    send_event(OP_SWITCH, 1'b0, 32'd0);
    send_event(OP_SWITCH, 1'b1, 32'd999);
    send_event(OP_SWITCH, 1'b0, 32'd1000);
  endtask

  task automatic test_turn_detents();
    // up, down, down across zero, up across the top
    now_us = 32'd2000;
    send_detent(1'b1, -1, 10);
    send_detent(1'b0, -1, 10);
    send_detent(1'b0, -1, 10);
    send_detent(1'b1, -1, 10);
  endtask

  task automatic test_unused_opcode();
    send_event(OpUnused, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_cooldown_extremes();
    // zero cooldown toggles even with no elapsed time
    write_cooldown(16'd0);
    send_event(OP_SWITCH, 1'b0, now_us);
    // largest cooldown across the timestamp wrap
    write_cooldown(16'hFFFF);
    send_event(OP_CLOCK, 1'b0, 32'hFFFF_FFFF);
    send_event(OP_SWITCH, 1'b0, 32'hFFFF_FFFF + 32'd65534);
    send_event(OP_SWITCH, 1'b1, 32'hFFFF_FFFF + 32'd65535);
    now_us = 32'hFFFF_FFFF + 32'd65535;
  endtask

  // mostly well-formed detents, plus switch edges near the cooldown and noise
  task automatic run_random_events(input int count);
    int stop_at;
    int pick;
    int gap;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 31) == 0) now_us = $urandom();
      if (pick < 6) begin
        send_detent(1'($urandom_range(0, 1)), -1, $urandom_range(1, 3000));
      end else if (pick < 8) begin
        gap = int'(cooldown_mdl) + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 3) == 0) gap = $urandom_range(0, 70000);
        if (gap < 0) gap = 0;
        now_us = now_us + gap;
        send_event(OP_SWITCH, 1'($urandom_range(0, 1)), now_us);
      end else if (pick == 8) begin
        send_detent(1'($urandom_range(0, 1)), $urandom_range(0, 3), 500);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          now_us = now_us + $urandom_range(0, 200);
          send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), now_us);
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    write_cooldown(16'($urandom_range(1, 4000)));
    run_random_events(110);
    write_cooldown(16'd0);
    run_random_events(110);
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering
    write_cooldown(16'hFFFF);
    hold_pending = 1'b1;
    run_random_events(110);
  endtask

  task automatic test_steady_stream();
    // no idling on either side, back at the reset value
    write_cooldown(CooldownReset);
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    run_random_events(110);
  endtask

  // stimulus sequence and verdict
  initial begin
    rst_ni            <= 1'b0;
    ev_if.valid       <= 1'b0;
    ev_if.opcode      <= OP_CLOCK;
    ev_if.other_level <= 1'b0;
    ev_if.time_us     <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_reset_cooldown();
    test_turn_detents();
    test_unused_opcode();
    test_cooldown_extremes();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results missing", expected_results.size(), '0);

    $display("covered %0d edge events over %0d cooldown settings", items_sent,
             settings_used);
    $display("decoded %0d increments and %0d decrements, %0d mismatches", inc_seen,
             dec_seen, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
